// File: design/apcp_pkg.sv
`timescale 1ns / 1ps
// apcp_pkg: shared types, codes and lookup functions of the command stream parser
// used by apcp_step and audio_path_command_stream_parser_core; no dependencies
package apcp_pkg;

    typedef enum logic [2:0] {
        PH_CMD       = 3'd0,
        PH_ADD_FIRST = 3'd1,
        PH_ADD_ZERO  = 3'd2,
        PH_STR       = 3'd3,
        PH_COUNT     = 3'd4,
        PH_TYPE      = 3'd5,
        PH_VALUE     = 3'd6
    } t_phase;

    // command kinds
    localparam logic [3:0] CMD_ADD        = 4'd0;
    localparam logic [3:0] CMD_CLEAR      = 4'd1;
    localparam logic [3:0] CMD_REMOVE     = 4'd2;
    localparam logic [3:0] CMD_CONNECT    = 4'd3;
    localparam logic [3:0] CMD_DISCONNECT = 4'd4;
    localparam logic [3:0] CMD_SET        = 4'd5;
    localparam logic [3:0] CMD_UPDATE     = 4'd6;
    localparam logic [3:0] CMD_UNSET_ALL  = 4'd7;
    localparam logic [3:0] CMD_UPDATE_ONE = 4'd8;
    localparam logic [3:0] CMD_UNSET      = 4'd9;

    // command opcode bytes
    localparam logic [7:0] OP_ADD        = 8'h49; // 'I'
    localparam logic [7:0] OP_REMOVE     = 8'h69; // 'i'
    localparam logic [7:0] OP_CONNECT    = 8'h43; // 'C'
    localparam logic [7:0] OP_DISCONNECT = 8'h63; // 'c'
    localparam logic [7:0] OP_SET        = 8'h53; // 'S'
    localparam logic [7:0] OP_UPDATE     = 8'h55; // 'U'
    localparam logic [7:0] OP_UPDATE_ONE = 8'h75; // 'u'
    localparam logic [7:0] OP_UNSET      = 8'h64; // 'd'

    // byte roles
    localparam logic [2:0] ROLE_CMD     = 3'd0;
    localparam logic [2:0] ROLE_CHAR    = 3'd1;
    localparam logic [2:0] ROLE_END     = 3'd2;
    localparam logic [2:0] ROLE_COUNT   = 3'd3;
    localparam logic [2:0] ROLE_TYPE    = 3'd4;
    localparam logic [2:0] ROLE_VALUE   = 3'd5;
    localparam logic [2:0] ROLE_DISCARD = 3'd6;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_CMD   = 3'd1;
    localparam logic [2:0] ERR_EMPTY     = 3'd2;
    localparam logic [2:0] ERR_UNPRINT   = 3'd3;
    localparam logic [2:0] ERR_BAD_TYPE  = 3'd4;
    localparam logic [2:0] ERR_BOOL      = 3'd5;
    localparam logic [2:0] ERR_JUNK      = 3'd6;
    localparam logic [2:0] ERR_TRUNCATED = 3'd7;

    // variant type codes
    localparam logic [3:0] TY_STRING = 4'd0;
    localparam logic [3:0] TY_BOOL   = 4'd1;
    localparam logic [3:0] TY_FIXED  = 4'd2;
    localparam logic [3:0] TY_INT8   = 4'd3;
    localparam logic [3:0] TY_UINT8  = 4'd4;
    localparam logic [3:0] TY_INT16  = 4'd5;
    localparam logic [3:0] TY_UINT16 = 4'd6;
    localparam logic [3:0] TY_INT32  = 4'd7;
    localparam logic [3:0] TY_UINT32 = 4'd8;
    localparam logic [3:0] TY_INT64  = 4'd9;
    localparam logic [3:0] TY_UINT64 = 4'd10;

    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7e;
    localparam logic [7:0] FIXED_JUNK_MASK = 8'hc0;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  cmd;
        logic [1:0]  field;
        logic [7:0]  pairs_left;
        logic [63:0] acc;
        logic [3:0]  bytes_left;
        logic [3:0]  ctype;
        logic        started;
        logic        latched;
    } t_parse_state;

    typedef struct packed {
        logic [2:0]  role;
        logic [3:0]  kind;
        logic [1:0]  field;
        logic [3:0]  ctype;
        logic [63:0] value;
        logic        value_done;
        logic        cmd_done;
        logic        cmd_dropped;
        logic [2:0]  err;
    } t_result;

    // returns {found, type code}
    function automatic logic [4:0] type_lookup(input logic [7:0] b);
        logic [4:0] res;
        case (b)
            8'h73:   res = {1'b1, TY_STRING}; // s
            8'h62:   res = {1'b1, TY_BOOL};   // b
            8'h44:   res = {1'b1, TY_FIXED};  // D
            8'h59:   res = {1'b1, TY_INT8};   // Y
            8'h79:   res = {1'b1, TY_UINT8};  // y
            8'h6e:   res = {1'b1, TY_INT16};  // n
            8'h71:   res = {1'b1, TY_UINT16}; // q
            8'h69:   res = {1'b1, TY_INT32};  // i
            8'h75:   res = {1'b1, TY_UINT32}; // u
            8'h78:   res = {1'b1, TY_INT64};  // x
            8'h74:   res = {1'b1, TY_UINT64}; // t
            default: res = {1'b0, TY_STRING};
        endcase
        return res;
    endfunction

    function automatic logic [3:0] type_len(input logic [3:0] ty);
        logic [3:0] len;
        case (ty)
            TY_BOOL, TY_INT8, TY_UINT8:     len = 4'd1;
            TY_FIXED, TY_INT16, TY_UINT16:  len = 4'd2;
            TY_INT32, TY_UINT32:            len = 4'd4;
            TY_INT64, TY_UINT64:            len = 4'd8;
            default:                        len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic [63:0] sign_fix(input logic [3:0] ty, input logic [63:0] v);
        logic [63:0] res;
        case (ty)
            TY_INT8:  res = {{56{v[7]}}, v[7:0]};
            TY_INT16: res = {{48{v[15]}}, v[15:0]};
            TY_INT32: res = {{32{v[31]}}, v[31:0]};
            default:  res = v;
        endcase
        return res;
    endfunction

endpackage

// File: design/apcp_step.sv
`timescale 1ns / 1ps
// apcp_step: combinational parse step for one buffer byte, next state and result
// depends on apcp_pkg
module apcp_step
    import apcp_pkg::*;
(
    input  t_parse_state i_state,
    input  logic [7:0]   i_byte,
    input  logic         i_last,
    output t_parse_state o_next,
    output t_result      o_result
);

    logic [4:0]  w_lookup;
    logic        w_found;
    logic [3:0]  w_tidx;
    logic        w_pair_end;
    logic        w_str_done;
    logic        w_empty_ok;
    logic        w_val_last;
    logic [63:0] w_shifted;
    logic [2:0]  w_err_raw;
    logic [2:0]  w_err;
    t_phase      w_phase_step;

    assign w_lookup  = type_lookup(i_byte);
    assign w_found   = w_lookup[4];
    assign w_tidx    = w_lookup[3:0];
    assign w_shifted = {i_state.acc[55:0], i_byte};
    assign w_val_last = (i_state.bytes_left <= 4'd1);
    // last pair of the command (counter wraps from zero like the 8-bit count)
    assign w_pair_end = (i_state.cmd == CMD_UPDATE_ONE) || (i_state.pairs_left == 8'd1);

    assign w_empty_ok = (i_state.cmd == CMD_DISCONNECT)
        || (((i_state.cmd == CMD_SET) || (i_state.cmd == CMD_UPDATE))
            && (i_state.pairs_left != 8'd0) && (i_state.field == 2'd2))
        || ((i_state.cmd == CMD_UPDATE_ONE) && (i_state.field == 2'd3));

    // terminator ends the command
    always_comb begin
        case (i_state.cmd)
            CMD_ADD, CMD_CONNECT, CMD_DISCONNECT, CMD_UNSET: begin
                w_str_done = (i_state.field != 2'd0);
            end
            CMD_SET, CMD_UPDATE: begin
                w_str_done = (i_state.pairs_left != 8'd0) && (i_state.field != 2'd0)
                             && w_pair_end;
            end
            CMD_UPDATE_ONE: begin
                w_str_done = (i_state.field != 2'd0) && (i_state.field != 2'd1);
            end
            default: begin
                w_str_done = 1'b1;
            end
        endcase
    end

    // byte-level errors
    always_comb begin
        w_err_raw = ERR_NONE;
        case (i_state.phase)
            PH_CMD: begin
                if (!((i_byte == OP_ADD) || (i_byte == OP_REMOVE) || (i_byte == OP_CONNECT)
                      || (i_byte == OP_DISCONNECT) || (i_byte == OP_SET)
                      || (i_byte == OP_UPDATE) || (i_byte == OP_UPDATE_ONE)
                      || (i_byte == OP_UNSET)))
                    w_err_raw = ERR_BAD_CMD;
            end
            PH_ADD_ZERO: begin
                if (i_byte != 8'd0) w_err_raw = ERR_EMPTY;
            end
            PH_STR: begin
                if ((i_byte == 8'd0) && !i_state.started && !w_empty_ok) w_err_raw = ERR_EMPTY;
            end
            PH_TYPE: begin
                if ((i_byte < PRINT_LO) || (i_byte > PRINT_HI)) w_err_raw = ERR_UNPRINT;
                else if (!w_found) w_err_raw = ERR_BAD_TYPE;
            end
            PH_VALUE: begin
                if ((i_state.ctype == TY_BOOL) && (i_byte > 8'd1))
                    w_err_raw = ERR_BOOL;
                else if ((i_state.ctype == TY_FIXED) && (i_state.bytes_left == 4'd1)
                         && ((i_state.acc[7:0] & FIXED_JUNK_MASK) != 8'd0))
                    w_err_raw = ERR_JUNK;
            end
            default: begin
                w_err_raw = ERR_NONE;
            end
        endcase
    end

    // next state
    always_comb begin
        o_next = i_state;
        w_phase_step = i_state.phase;
        case (i_state.phase)
            PH_CMD: begin
                o_next.field      = 2'd0;
                o_next.pairs_left = 8'd0;
                o_next.started    = 1'b0;
                o_next.ctype      = TY_STRING;
                w_phase_step      = PH_STR;
                case (i_byte)
                    OP_ADD: begin
                        o_next.cmd   = CMD_ADD;
                        w_phase_step = PH_ADD_FIRST;
                    end
                    OP_REMOVE:     o_next.cmd = CMD_REMOVE;
                    OP_CONNECT:    o_next.cmd = CMD_CONNECT;
                    OP_DISCONNECT: o_next.cmd = CMD_DISCONNECT;
                    OP_SET:        o_next.cmd = CMD_SET;
                    OP_UPDATE:     o_next.cmd = CMD_UPDATE;
                    OP_UPDATE_ONE: o_next.cmd = CMD_UPDATE_ONE;
                    OP_UNSET:      o_next.cmd = CMD_UNSET;
                    default:       o_next.cmd = CMD_ADD;
                endcase
            end
            PH_ADD_FIRST: begin
                if (i_byte == 8'd0) begin
                    w_phase_step = PH_ADD_ZERO;
                end else begin
                    o_next.started = 1'b1;
                    w_phase_step   = PH_STR;
                end
            end
            PH_ADD_ZERO: begin
                if (w_err_raw == ERR_NONE) begin
                    o_next.cmd   = CMD_CLEAR;
                    w_phase_step = PH_CMD;
                end
            end
            PH_STR: begin
                if (i_byte != 8'd0) begin
                    o_next.started = 1'b1;
                end else if (w_err_raw == ERR_NONE) begin
                    o_next.started = 1'b0;
                    case (i_state.cmd)
                        CMD_SET, CMD_UPDATE: begin
                            if (i_state.pairs_left == 8'd0) begin
                                o_next.field = 2'd1;
                                w_phase_step = PH_COUNT;
                            end else if (i_state.field == 2'd0) begin
                                o_next.field = 2'd1;
                                w_phase_step = PH_TYPE;
                            end else begin
                                o_next.pairs_left = i_state.pairs_left - 8'd1;
                                if (w_pair_end) begin
                                    w_phase_step = PH_CMD;
                                end else begin
                                    o_next.field = 2'd0;
                                end
                            end
                        end
                        CMD_UPDATE_ONE: begin
                            if (i_state.field == 2'd0) begin
                                o_next.field = 2'd1;
                            end else if (i_state.field == 2'd1) begin
                                o_next.field = 2'd2;
                                w_phase_step = PH_TYPE;
                            end else begin
                                w_phase_step = PH_CMD;
                            end
                        end
                        default: begin
                            if (w_str_done) w_phase_step = PH_CMD;
                            else o_next.field = 2'd1;
                        end
                    endcase
                end
            end
            PH_COUNT: begin
                if (i_byte == 8'd0) begin
                    if (i_state.cmd == CMD_SET) o_next.cmd = CMD_UNSET_ALL;
                    w_phase_step = PH_CMD;
                end else begin
                    o_next.pairs_left = i_byte;
                    o_next.field      = 2'd0;
                    o_next.started    = 1'b0;
                    w_phase_step      = PH_STR;
                end
            end
            PH_TYPE: begin
                if (w_err_raw == ERR_NONE) begin
                    o_next.ctype = w_tidx;
                    o_next.field = i_state.field + 2'd1;
                    if (w_tidx == TY_STRING) begin
                        o_next.started = 1'b0;
                        w_phase_step   = PH_STR;
                    end else begin
                        o_next.acc        = 64'd0;
                        o_next.bytes_left = type_len(w_tidx);
                        w_phase_step      = PH_VALUE;
                    end
                end
            end
            PH_VALUE: begin
                if (w_err_raw == ERR_NONE) begin
                    o_next.acc = w_shifted;
                    if (i_state.bytes_left != 4'd0)
                        o_next.bytes_left = i_state.bytes_left - 4'd1;
                    if (w_val_last && (i_state.cmd != CMD_UPDATE_ONE)) begin
                        o_next.pairs_left = i_state.pairs_left - 8'd1;
                    end
                    if (w_val_last) begin
                        if (w_pair_end) begin
                            w_phase_step = PH_CMD;
                        end else begin
                            o_next.field   = 2'd0;
                            o_next.started = 1'b0;
                            w_phase_step   = PH_STR;
                        end
                    end
                end
            end
            default: begin
                w_phase_step = PH_CMD;
            end
        endcase

        if (i_last && (w_err_raw == ERR_NONE) && (w_phase_step != PH_CMD))
            w_err = ERR_TRUNCATED;
        else
            w_err = w_err_raw;

        o_next.phase = (w_err != ERR_NONE) ? PH_CMD : w_phase_step;
        o_next.latched = (w_err != ERR_NONE) && !i_last;

        // discarding: only the latch moves, cleared on the last byte
        if (i_state.latched) begin
            o_next = i_state;
            o_next.latched = !i_last;
        end
    end

    // result
    always_comb begin
        o_result = '0;
        o_result.kind = o_next.cmd;
        case (i_state.phase)
            PH_CMD: begin
                o_result.role = ROLE_CMD;
            end
            PH_ADD_FIRST: begin
                o_result.role = (i_byte == 8'd0) ? ROLE_END : ROLE_CHAR;
            end
            PH_ADD_ZERO: begin
                o_result.role     = ROLE_END;
                o_result.field    = 2'd1;
                o_result.cmd_done = 1'b1;
            end
            PH_STR: begin
                o_result.role     = (i_byte == 8'd0) ? ROLE_END : ROLE_CHAR;
                o_result.field    = i_state.field;
                o_result.ctype    = i_state.ctype;
                o_result.cmd_done = (i_byte == 8'd0) && w_str_done;
            end
            PH_COUNT: begin
                o_result.role        = ROLE_COUNT;
                o_result.field       = 2'd1;
                o_result.cmd_done    = (i_byte == 8'd0);
                o_result.cmd_dropped = (i_byte == 8'd0) && (i_state.cmd != CMD_SET);
            end
            PH_TYPE: begin
                o_result.role  = ROLE_TYPE;
                o_result.field = i_state.field;
                o_result.ctype = w_tidx;
            end
            PH_VALUE: begin
                o_result.role  = ROLE_VALUE;
                o_result.field = i_state.field;
                o_result.ctype = i_state.ctype;
                if (w_val_last) begin
                    o_result.value      = sign_fix(i_state.ctype, w_shifted);
                    o_result.value_done = 1'b1;
                    o_result.cmd_done   = w_pair_end;
                end
            end
            default: begin
                o_result.role = ROLE_CMD;
            end
        endcase

        if (w_err != ERR_NONE) begin
            o_result = '0;
            o_result.role = ROLE_DISCARD;
            o_result.kind = o_next.cmd;
            o_result.err  = w_err;
        end

        if (i_state.latched) begin
            o_result = '0;
            o_result.role = ROLE_DISCARD;
        end
    end

endmodule

// File: design/audio_path_command_stream_parser_core.sv
`timescale 1ns / 1ps
// audio_path_command_stream_parser_core: top level of the command stream parser
// depends on apcp_pkg and apcp_step
//
// usage:
//   slave channel: one byte of a binary command buffer per beat, s_axis_tlast on
//   the last byte of the buffer. master channel: one result beat per input beat,
//   byte role on m_axis_tuser, classification and assembled value on m_axis_tdata.
//   the result of a byte is registered and appears in the cycle after it is accepted.
//   throughput: one byte per cycle unless the receiver stalls; the parse state
//   register is updated as each byte is accepted, so consecutive bytes need no gap.
//   the result register frees up in the cycle it is taken, so s_axis_tready
//   stays high while the receiver takes every beat.
//   when the receiver stalls, the finished result holds in the output register
//   and s_axis_tready drops until it is taken; no beat is lost or repeated.
//   after an error the remaining bytes of the buffer come out as discarded.
//   reset: parse state returns to expecting a command byte, the discard latch
//   clears and the output register is emptied.
module audio_path_command_stream_parser_core
    import apcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // buffer_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // command_kind[3:0], field_number[5:4], type_code[9:6], value_word[73:10],
    // value_done[74], command_done[75], command_dropped[76], error_code[79:77]
    output logic [79:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser    // byte_role
);

    t_parse_state r_state;
    t_parse_state n_state;
    t_result      w_result;
    t_result      r_result;
    logic         r_out_valid;
    logic         w_accept;

    apcp_step u_step (
        .i_state  (r_state),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_next   (n_state),
        .o_result (w_result)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) r_state <= n_state;
            if (w_accept) r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    // result payload, loaded on every accepted beat
    always_ff @(posedge i_clk) begin
        if (w_accept) r_result <= w_result;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_result.role;
    assign m_axis_tdata  = {r_result.err, r_result.cmd_dropped, r_result.cmd_done,
                            r_result.value_done, r_result.value, r_result.ctype,
                            r_result.field, r_result.kind};

endmodule
